// File: rtl/core/point_box_penetration_resolve_macros.svh
// assertion macros used by the checker
`ifndef POINT_BOX_PENETRATION_RESOLVE_MACROS_SVH
`define POINT_BOX_PENETRATION_RESOLVE_MACROS_SVH

// property holds at every clock edge out of reset
`define PBPR_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// trigger implies a condition in the following cycle
`define PBPR_ASSERT_NEXT(lbl, trig, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (expr)) else $error(msg);

`endif

// File: rtl/core/pbpr_pkg.sv
package pbpr_pkg;

  localparam int FIELD_BITS          = 63;
  localparam int COMPONENT_BITS_DEF  = 21;
  localparam int FRACTION_BITS_DEF   = 10;

  localparam int EXT_BITS  = 14;
  localparam int BIAS_BITS = 12;
  localparam int SKIN_BITS = 10;
  localparam int GAIN_BITS = 11;
  localparam int CFG_BITS  = 14;
  localparam int IDX_BITS  = 3;

  localparam int IN_DATA_BITS  = 448;
  localparam int OUT_DATA_BITS = 136;

  // register indexes
  localparam logic [IDX_BITS-1:0] REG_HALF_WIDTH  = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_HALF_HEIGHT = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_HALF_LENGTH = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_ROOF_BIAS   = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_SKIN_MARGIN = 3'd4;
  localparam logic [IDX_BITS-1:0] REG_BOUNCE_GAIN = 3'd5;

  // reset values
  localparam logic [EXT_BITS-1:0]         RST_HALF_WIDTH  = 14'd1280;
  localparam logic [EXT_BITS-1:0]         RST_HALF_HEIGHT = 14'd1075;
  localparam logic [EXT_BITS-1:0]         RST_HALF_LENGTH = 14'd2816;
  localparam logic signed [BIAS_BITS-1:0] RST_ROOF_BIAS   = -12'sd205;
  localparam logic [SKIN_BITS-1:0]        RST_SKIN_MARGIN = 10'd82;
  localparam logic [GAIN_BITS-1:0]        RST_BOUNCE_GAIN = 11'd1106;

  // contact face codes
  localparam logic [2:0] FACE_NONE       = 3'd0;
  localparam logic [2:0] FACE_UP         = 3'd1;
  localparam logic [2:0] FACE_DOWN       = 3'd2;
  localparam logic [2:0] FACE_POS_RIGHT  = 3'd3;
  localparam logic [2:0] FACE_NEG_RIGHT  = 3'd4;
  localparam logic [2:0] FACE_POS_BACK   = 3'd5;
  localparam logic [2:0] FACE_NEG_BACK   = 3'd6;

endpackage

// File: rtl/core/point_box_penetration_resolve.sv
// Pushes a point out of an oriented box and reflects its inward speed. One point
// is taken per cycle while the output is not stalled; each result passes through
// the seven register stages (three for the box-space projection, four for face
// choice, push-out multiply, rescale and velocity update). A stalled output
// holds the whole pipeline, and the input is ready whenever the output register
// is empty or being taken. Configuration registers are written through a plain
// write port and must only change while no point is in flight.
module point_box_penetration_resolve #(
  parameter int COMPONENT_BITS = pbpr_pkg::COMPONENT_BITS_DEF,
  parameter int FRACTION_BITS  = pbpr_pkg::FRACTION_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  // point_position, point_velocity, box_center, box_right_axis, box_up_axis,
  // box_back_axis, box_velocity (63 bits each), zero pad
  input  logic [pbpr_pkg::IN_DATA_BITS-1:0]  s_tdata,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // new_position (63), new_velocity (63), contact_face (3), speed_reflected (1),
  // zero pad
  output logic [pbpr_pkg::OUT_DATA_BITS-1:0] m_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  input  logic                               cfg_write,
  input  logic [pbpr_pkg::IDX_BITS-1:0]      cfg_index,
  input  logic [pbpr_pkg::CFG_BITS-1:0]      cfg_data
);

  localparam int C  = COMPONENT_BITS;
  localparam int FB = pbpr_pkg::FIELD_BITS;
  localparam int LW = 2 * C + 4 - FRACTION_BITS;

  logic [pbpr_pkg::EXT_BITS-1:0]         half_width, half_height, half_length;
  logic signed [pbpr_pkg::BIAS_BITS-1:0] roof_bias;
  logic [pbpr_pkg::SKIN_BITS-1:0]        skin_margin;
  logic [pbpr_pkg::GAIN_BITS-1:0]        bounce_gain;

  logic en;
  logic signed [C-1:0] pos [3], vel [3], ctr [3], ax [3][3], bvel [3];
  logic signed [C-1:0] p_pos [3], p_vel [3], p_ax [3][3];
  logic signed [LW-1:0] loc [3], rvd [3], rvn [3];
  logic p_valid;
  logic signed [C-1:0] new_pos [3], new_vel [3];
  logic [2:0] face;
  logic refl;
  logic [FB-1:0] npos_w, nvel_w;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      half_width  <= pbpr_pkg::RST_HALF_WIDTH;
      half_height <= pbpr_pkg::RST_HALF_HEIGHT;
      half_length <= pbpr_pkg::RST_HALF_LENGTH;
      roof_bias   <= pbpr_pkg::RST_ROOF_BIAS;
      skin_margin <= pbpr_pkg::RST_SKIN_MARGIN;
      bounce_gain <= pbpr_pkg::RST_BOUNCE_GAIN;
    end else if (cfg_write) begin
      case (cfg_index)
        pbpr_pkg::REG_HALF_WIDTH:  half_width  <= cfg_data[pbpr_pkg::EXT_BITS-1:0];
        pbpr_pkg::REG_HALF_HEIGHT: half_height <= cfg_data[pbpr_pkg::EXT_BITS-1:0];
        pbpr_pkg::REG_HALF_LENGTH: half_length <= cfg_data[pbpr_pkg::EXT_BITS-1:0];
        pbpr_pkg::REG_ROOF_BIAS:   roof_bias   <= cfg_data[pbpr_pkg::BIAS_BITS-1:0];
        pbpr_pkg::REG_SKIN_MARGIN: skin_margin <= cfg_data[pbpr_pkg::SKIN_BITS-1:0];
        pbpr_pkg::REG_BOUNCE_GAIN: bounce_gain <= cfg_data[pbpr_pkg::GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advances unless the output register is held
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // unpack input components
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pos[i]   = s_tdata[0*FB + i*C +: C];
      vel[i]   = s_tdata[1*FB + i*C +: C];
      ctr[i]   = s_tdata[2*FB + i*C +: C];
      ax[0][i] = s_tdata[3*FB + i*C +: C];
      ax[1][i] = s_tdata[4*FB + i*C +: C];
      ax[2][i] = s_tdata[5*FB + i*C +: C];
      bvel[i]  = s_tdata[6*FB + i*C +: C];
    end
  end

  pbpr_proj #(.C(C), .F(FRACTION_BITS)) u_proj (
    .clk(clk), .rst(rst), .en(en), .in_valid(s_tvalid),
    .pos(pos), .vel(vel), .ctr(ctr), .ax(ax), .bvel(bvel),
    .out_valid(p_valid), .pos_o(p_pos), .vel_o(p_vel), .ax_o(p_ax),
    .loc(loc), .rvd(rvd), .rvn(rvn)
  );

  pbpr_resolve #(.C(C), .F(FRACTION_BITS)) u_resolve (
    .clk(clk), .rst(rst), .en(en), .in_valid(p_valid),
    .pos(p_pos), .vel(p_vel), .ax(p_ax), .loc(loc), .rvd(rvd), .rvn(rvn),
    .half_width(half_width), .half_height(half_height), .half_length(half_length),
    .roof_bias(roof_bias), .skin_margin(skin_margin), .bounce_gain(bounce_gain),
    .out_valid(m_tvalid), .new_pos(new_pos), .new_vel(new_vel),
    .face(face), .refl(refl)
  );

  // repack results
  always_comb begin
    npos_w = '0;
    nvel_w = '0;
    for (int i = 0; i < 3; i++) begin
      npos_w[i*C +: C] = new_pos[i];
      nvel_w[i*C +: C] = new_vel[i];
    end
    m_tdata = {6'd0, refl, face, nvel_w, npos_w};
  end

endmodule

// File: rtl/core/pbpr_proj.sv
// box-space projection: relative vectors, products, rounded dot sums
module pbpr_proj #(
  parameter int C = pbpr_pkg::COMPONENT_BITS_DEF,
  parameter int F = pbpr_pkg::FRACTION_BITS_DEF,
  localparam int RW = C + 1,
  localparam int PW = RW + C,
  localparam int SW = PW + 2,
  localparam int LW = SW + 1 - F
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [C-1:0] pos [3],
  input  logic signed [C-1:0] vel [3],
  input  logic signed [C-1:0] ctr [3],
  input  logic signed [C-1:0] ax [3][3],
  input  logic signed [C-1:0] bvel [3],
  output logic                out_valid,
  output logic signed [C-1:0] pos_o [3],
  output logic signed [C-1:0] vel_o [3],
  output logic signed [C-1:0] ax_o [3][3],
  output logic signed [LW-1:0] loc [3],
  output logic signed [LW-1:0] rvd [3],
  output logic signed [LW-1:0] rvn [3]
);

  localparam int HALF = 1 << (F - 1);

  logic v1, v2, v3;
  logic signed [C-1:0]  pos1 [3], vel1 [3], ax1 [3][3];
  logic signed [C-1:0]  pos2 [3], vel2 [3], ax2 [3][3];
  logic signed [C-1:0]  pos3 [3], vel3 [3], ax3 [3][3];
  logic signed [RW-1:0] rel1 [3], rv1 [3];
  logic signed [PW-1:0] pl2 [3][3], pv2 [3][3];
  logic signed [LW-1:0] loc3 [3], rvd3 [3], rvn3 [3];
  logic signed [SW-1:0] sl_next [3], sv_next [3];

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // dot sums with round to nearest
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sl_next[a] = SW'(pl2[a][0]) + SW'(pl2[a][1]) + SW'(pl2[a][2]) + SW'(HALF);
      sv_next[a] = SW'(pv2[a][0]) + SW'(pv2[a][1]) + SW'(pv2[a][2]) + SW'(HALF);
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        rel1[i] <= RW'(pos[i]) - RW'(ctr[i]);
        rv1[i]  <= RW'(vel[i]) - RW'(bvel[i]);
      end
      pos1 <= pos;
      vel1 <= vel;
      ax1  <= ax;
      for (int a = 0; a < 3; a++) begin
        for (int i = 0; i < 3; i++) begin
          pl2[a][i] <= PW'(rel1[i]) * PW'(ax1[a][i]);
          pv2[a][i] <= PW'(rv1[i]) * PW'(ax1[a][i]);
        end
      end
      pos2 <= pos1;
      vel2 <= vel1;
      ax2  <= ax1;
      for (int a = 0; a < 3; a++) begin
        loc3[a] <= LW'(sl_next[a] >>> F);
        rvd3[a] <= LW'(sv_next[a] >>> F);
        // rounding for a negated normal: ties land one step lower
        rvn3[a] <= LW'((sv_next[a] - SW'(1)) >>> F);
      end
      pos3 <= pos2;
      vel3 <= vel2;
      ax3  <= ax2;
    end
  end

  assign out_valid = v3;
  assign pos_o     = pos3;
  assign vel_o     = vel3;
  assign ax_o      = ax3;
  assign loc       = loc3;
  assign rvd       = rvd3;
  assign rvn       = rvn3;

endmodule

// File: rtl/core/pbpr_resolve.sv
// face choice, push-out and speed reflection
module pbpr_resolve #(
  parameter int C = pbpr_pkg::COMPONENT_BITS_DEF,
  parameter int F = pbpr_pkg::FRACTION_BITS_DEF,
  localparam int LW = 2 * C + 4 - F
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [C-1:0] pos [3],
  input  logic signed [C-1:0] vel [3],
  input  logic signed [C-1:0] ax [3][3],
  input  logic signed [LW-1:0] loc [3],
  input  logic signed [LW-1:0] rvd [3],
  input  logic signed [LW-1:0] rvn [3],
  input  logic [pbpr_pkg::EXT_BITS-1:0]         half_width,
  input  logic [pbpr_pkg::EXT_BITS-1:0]         half_height,
  input  logic [pbpr_pkg::EXT_BITS-1:0]         half_length,
  input  logic signed [pbpr_pkg::BIAS_BITS-1:0] roof_bias,
  input  logic [pbpr_pkg::SKIN_BITS-1:0]        skin_margin,
  input  logic [pbpr_pkg::GAIN_BITS-1:0]        bounce_gain,
  output logic                out_valid,
  output logic signed [C-1:0] new_pos [3],
  output logic signed [C-1:0] new_vel [3],
  output logic [2:0]          face,
  output logic                refl
);

  localparam int EB   = pbpr_pkg::EXT_BITS;
  localparam int NW   = C + 1;
  localparam int IW   = LW + 1;
  localparam int DW   = EB + 1;
  localparam int MPW  = NW + DW + 1;
  localparam int GW   = IW + 1 + pbpr_pkg::GAIN_BITS + 1;
  localparam int RPW  = GW + 1 - F;
  localparam int NPW  = NW + RPW;
  localparam int EPW  = MPW + 2 - F;
  localparam int EVW  = NPW + 2 - F;
  localparam int HALF = 1 << (F - 1);
  localparam int CMAX = (1 << (C - 1)) - 1;
  localparam int CMIN = -(1 << (C - 1));

  // choice stage signals
  logic [LW-1:0]        ab [3];
  logic                 in_box;
  logic [EB-1:0]        px, py, pz, depth;
  logic                 sgn;
  logic [1:0]           idx;
  logic [2:0]           face_next;
  logic signed [NW-1:0] nrm_next [3];
  logic signed [IW-1:0] inw_next;

  logic v4, v5, v6, v7;
  logic                 ins4, ins5, ins6, ins7;
  logic [2:0]           face4, face5, face6, face7;
  logic signed [NW-1:0] nrm4 [3], nrm5 [3];
  logic signed [IW-1:0] inw4;
  logic [DW-1:0]        corr4;
  logic signed [C-1:0]  pos4 [3], pos5 [3], vel4 [3], vel5 [3], vel6 [3];
  logic signed [MPW-1:0] mp5 [3];
  logic signed [GW-1:0] gp5;
  logic                 neg5, neg6;
  logic signed [RPW-1:0] resp;
  logic signed [GW-1:0] gr;
  logic signed [EPW-1:0] ep [3];
  logic signed [C-1:0]  np_next [3];
  logic signed [C-1:0]  npos6 [3], npos7 [3];
  logic signed [NPW-1:0] mv6 [3];
  logic signed [EVW-1:0] ev [3];
  logic signed [C-1:0]  nv_next [3];
  logic signed [C-1:0]  nvel7 [3];
  logic                 refl7;

  // inside test and shallowest face
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ab[i] = loc[i][LW-1] ? LW'(-loc[i]) : LW'(loc[i]);
    end
    in_box = (ab[0] <= LW'(half_width)) && (ab[1] <= LW'(half_height)) &&
             (ab[2] <= LW'(half_length));
    px = half_width - ab[0][EB-1:0];
    py = half_height - ab[1][EB-1:0];
    pz = half_length - ab[2][EB-1:0];
    if (py <= px && py <= pz) begin
      idx       = 2'd1;
      depth     = py;
      sgn       = loc[1] >= LW'(roof_bias);
      face_next = sgn ? pbpr_pkg::FACE_UP : pbpr_pkg::FACE_DOWN;
    end else if (px <= pz) begin
      idx       = 2'd0;
      depth     = px;
      sgn       = !loc[0][LW-1];
      face_next = sgn ? pbpr_pkg::FACE_POS_RIGHT : pbpr_pkg::FACE_NEG_RIGHT;
    end else begin
      idx       = 2'd2;
      depth     = pz;
      sgn       = !loc[2][LW-1];
      face_next = sgn ? pbpr_pkg::FACE_POS_BACK : pbpr_pkg::FACE_NEG_BACK;
    end
    for (int i = 0; i < 3; i++) begin
      nrm_next[i] = sgn ? NW'(ax[idx][i]) : -NW'(ax[idx][i]);
    end
    // a negated normal needs the sum rounded with ties the other way
    inw_next = sgn ? IW'(rvd[idx]) : -IW'(rvn[idx]);
  end

  // rescale products and saturate
  always_comb begin
    gr   = gp5 + GW'(HALF);
    resp = RPW'(gr >>> F);
    for (int i = 0; i < 3; i++) begin
      ep[i] = EPW'(pos5[i]) + EPW'((mp5[i] + MPW'(HALF)) >>> F);
      if (ep[i] > EPW'(CMAX)) begin
        np_next[i] = C'(CMAX);
      end else if (ep[i] < EPW'(CMIN)) begin
        np_next[i] = C'(CMIN);
      end else begin
        np_next[i] = C'(ep[i]);
      end
      ev[i] = EVW'(vel6[i]) + EVW'((mv6[i] + NPW'(HALF)) >>> F);
      if (ev[i] > EVW'(CMAX)) begin
        nv_next[i] = C'(CMAX);
      end else if (ev[i] < EVW'(CMIN)) begin
        nv_next[i] = C'(CMIN);
      end else begin
        nv_next[i] = C'(ev[i]);
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else if (en) begin
      v4 <= in_valid;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      ins4  <= in_box;
      face4 <= in_box ? face_next : pbpr_pkg::FACE_NONE;
      nrm4  <= nrm_next;
      inw4  <= inw_next;
      corr4 <= DW'(depth) + DW'(skin_margin);
      pos4  <= pos;
      vel4  <= vel;
      for (int i = 0; i < 3; i++) begin
        mp5[i] <= MPW'(nrm4[i]) * MPW'($signed({1'b0, corr4}));
      end
      gp5   <= GW'(-inw4) * GW'($signed({1'b0, bounce_gain}));
      neg5  <= inw4[IW-1];
      ins5  <= ins4;
      face5 <= face4;
      nrm5  <= nrm4;
      pos5  <= pos4;
      vel5  <= vel4;
      for (int i = 0; i < 3; i++) begin
        mv6[i]   <= NPW'(nrm5[i]) * NPW'(resp);
        npos6[i] <= ins5 ? np_next[i] : pos5[i];
      end
      neg6  <= neg5;
      ins6  <= ins5;
      face6 <= face5;
      vel6  <= vel5;
      ins7  <= ins6;
      face7 <= face6;
      npos7 <= npos6;
      refl7 <= ins6 && neg6;
      for (int i = 0; i < 3; i++) begin
        nvel7[i] <= (ins6 && neg6) ? nv_next[i] : vel6[i];
      end
    end
  end

  assign out_valid = v7;
  assign new_pos   = npos7;
  assign new_vel   = nvel7;
  assign face      = face7;
  assign refl      = refl7 && ins7;

endmodule

// File: rtl/core/pbpr_checker.sv
`include "point_box_penetration_resolve_macros.svh"

// port-level checks on the result stream
module pbpr_checker (
  input logic                               clk,
  input logic                               rst,
  input logic [pbpr_pkg::OUT_DATA_BITS-1:0] m_tdata,
  input logic                               m_tvalid,
  input logic                               m_tready
);

  logic [2:0] face;
  logic       refl;

  assign face = m_tdata[128:126];
  assign refl = m_tdata[129];

  `PBPR_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
  `PBPR_ASSERT(a_face, !m_tvalid || face <= pbpr_pkg::FACE_NEG_BACK, "contact face out of range")
  `PBPR_ASSERT(a_refl, !m_tvalid || !refl || face != pbpr_pkg::FACE_NONE, "reflection without contact")
  `PBPR_ASSERT(a_pad, !m_tvalid || m_tdata[135:130] == 6'd0, "padding bits set")

endmodule

bind point_box_penetration_resolve pbpr_checker u_pbpr_checker (
  .clk(clk), .rst(rst), .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready)
);
